// ----- rtl/core/flir_pkg.sv -----
// ----------------------------------------------------------------------------
// flir_pkg
// Shared types and constants of the fir linear interpolation resampler:
// transaction structs, opcodes, register indexes, fixed-point formats and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package flir_pkg;

    // sample and coefficient formats (q1.15)
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int CIDX_W       = 5;
    localparam int NUM_TAPS_DEF = 32;
    localparam int SMP_MAX      = 2 ** (SAMPLE_W - 1) - 1;
    localparam int SMP_MIN      = -(2 ** (SAMPLE_W - 1));
    localparam int Q_SH         = 15;
    localparam int RND_HALF     = 2 ** (Q_SH - 1);

    // phase accumulator, q3.29
    localparam int PHASE_W             = 32;
    localparam int PH_M1_W             = 31;
    localparam logic [PHASE_W-1:0] PH_ONE   = 32'h2000_0000;
    localparam logic [PHASE_W-1:0] PH_TWO   = 32'h4000_0000;
    localparam logic [PHASE_W-1:0] STEP_MAX = 32'h8000_0000;

    // fraction product and q.15 fraction
    localparam int INV_W     = 32;
    localparam int PROD_W    = PH_M1_W + INV_W;
    localparam int PROD_SH   = 37;
    localparam int FRAC_W    = 16;
    localparam int FRAC_ONE  = 32768;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV  = 1'b1;
    localparam logic [PHASE_W-1:0] STEP_RST   = 32'd194783102;
    localparam logic [INV_W-1:0]   INV_RST    = 32'd46242202;

    // item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [CIDX_W-1:0]          coef_index;
        logic signed [COEF_W-1:0]   coef_value;
        logic                       last_in_block;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       last_of_run;
        logic                       block_end;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mac_issue;
        logic fir_done;
        logic prod_load;
        logic frac_load;
        logic imul_load;
        logic res_load;
        logic item_done;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_is_sample;
        logic mac_last;
        logic pipe_empty;
        logic phase_ge_one;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/core/fir_linear_interp_resampler.sv -----
// ----------------------------------------------------------------------------
// fir_linear_interp_resampler
// FIR anti-alias filter followed by a phase-driven linear interpolator.
// ----------------------------------------------------------------------------
// A coefficient transaction is only stored. A sample transaction runs the tap
// loop, drains the tap pipeline and then forms R results, where R (0 to 4) is
// the number of results it causes; a result may wait on a stalled output
// register. The tap loop dominates, since one multiply-accumulate reads one
// delay line entry and one coefficient per cycle from single-port memories.
// Results sit in an output register, so the next transaction is taken while
// the last result of the previous one still waits. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
module fir_linear_interp_resampler #(
    parameter int NUM_TAPS = flir_pkg::NUM_TAPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  flir_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output flir_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [flir_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [flir_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import flir_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    flir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // filter, phase and interpolation datapath
    flir_dpath #(
        .NUM_TAPS (NUM_TAPS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/core/flir_ctrl.sv -----
// ----------------------------------------------------------------------------
// flir_ctrl
// Sequencer of the resampler: accepts items, runs the tap loop, then steps
// the interpolation unit once per output while the phase is at least one.
// ----------------------------------------------------------------------------
module flir_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  flir_pkg::t_dp_sts i_sts,
    output flir_pkg::t_dp_cmd o_cmd
);
    import flir_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAC   = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_FIR   = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_FRAC  = 4'd6;
    localparam logic [3:0] S_IMUL  = 4'd7;
    localparam logic [3:0] S_RES   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_dp_cmd    cmd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_sts.in_is_sample) begin
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                cmd.mac_issue = 1'b1;
                if (i_sts.mac_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_FIR;
                end
            end
            S_FIR: begin
                cmd.fir_done = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.phase_ge_one) begin
                    n_state = S_MUL;
                end else begin
                    cmd.item_done = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_MUL: begin
                cmd.prod_load = 1'b1;
                n_state       = S_FRAC;
            end
            S_FRAC: begin
                cmd.frac_load = 1'b1;
                n_state       = S_IMUL;
            end
            S_IMUL: begin
                cmd.imul_load = 1'b1;
                n_state       = S_RES;
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

    // filter result is only taken once the tap pipeline has emptied
    a_fir_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIR) |-> i_sts.pipe_empty)
        else $error("filter result taken with taps still in flight");

    // tap loop leaves only through the drain wait
    a_mac_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |=> (r_state == S_MAC) || (r_state == S_DRAIN))
        else $error("tap loop left without draining");

endmodule

// ----- rtl/core/flir_dpath.sv -----
// ----------------------------------------------------------------------------
// flir_dpath
// Datapath of the resampler: delay line and coefficient memories, one
// multiply-accumulate pipeline, phase accumulator, interpolation unit and
// the output register.
// ----------------------------------------------------------------------------
module flir_dpath #(
    parameter int NUM_TAPS = flir_pkg::NUM_TAPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  flir_pkg::t_in_item                i_in_data,
    input  logic                              i_cfg_we,
    input  logic [flir_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [flir_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  flir_pkg::t_dp_cmd                 i_cmd,
    output flir_pkg::t_dp_sts                 o_sts,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output flir_pkg::t_out_item               o_out_data
);
    import flir_pkg::*;

    localparam int AW     = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int MP_W   = COEF_W + SAMPLE_W;
    localparam int ACC_W  = MP_W + $clog2(NUM_TAPS) + 1;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int IP_W   = DIFF_W + FRAC_W + 1;
    localparam int T_W    = PROD_W - PROD_SH;
    localparam logic [AW-1:0]            LAST_POS = AW'(NUM_TAPS - 1);
    localparam logic signed [ACC_W-1:0]  ACC_HI   = ACC_W'(SMP_MAX);
    localparam logic signed [ACC_W-1:0]  ACC_LO   = ACC_W'(SMP_MIN);
    localparam logic signed [IP_W-1:0]   IP_HI    = IP_W'(SMP_MAX);
    localparam logic signed [IP_W-1:0]   IP_LO    = IP_W'(SMP_MIN);

    // memories and their valid bits
    logic signed [SAMPLE_W-1:0] r_dly_mem [NUM_TAPS];
    logic signed [COEF_W-1:0]   r_coef_mem [NUM_TAPS];
    logic [NUM_TAPS-1:0]        r_dly_vld;
    logic [NUM_TAPS-1:0]        r_coef_vld;

    // tap loop
    logic [AW-1:0]              r_wpos;
    logic [AW-1:0]              r_rd_pos;
    logic [AW-1:0]              r_cnt;
    logic                       r_q_vld;
    logic                       r_p_vld;
    logic signed [SAMPLE_W-1:0] r_dq;
    logic                       r_dv;
    logic signed [COEF_W-1:0]   r_cq;
    logic                       r_cv;
    logic signed [MP_W-1:0]     r_mprod;
    logic signed [ACC_W-1:0]    r_acc;

    // phase and interpolation
    logic signed [SAMPLE_W-1:0] r_cur;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic [PHASE_W-1:0]         r_phase;
    logic [PHASE_W-1:0]         r_step;
    logic [INV_W-1:0]           r_inv;
    logic [PROD_W-1:0]          r_prod;
    logic [FRAC_W-1:0]          r_frac;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [IP_W-1:0]     r_iprod;
    logic                       r_last_blk;
    logic                       r_out_vld;
    t_out_item                  r_out;

    logic                       smp_wr;
    logic                       coef_wr;
    logic [8:0]                 cidx_ext;
    logic [AW-1:0]              coef_waddr;
    logic [AW-1:0]              rd_pos_dec;
    logic [AW-1:0]              wpos_inc;
    logic signed [SAMPLE_W-1:0] dq_eff;
    logic signed [COEF_W-1:0]   cq_eff;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [ACC_W-1:0]    acc_sh;
    logic signed [SAMPLE_W-1:0] fir_sat;
    logic [PHASE_W-1:0]         step_eff;
    logic [PH_M1_W-1:0]         ph_m1;
    logic [T_W-1:0]             t_raw;
    logic [T_W:0]               t_inc;
    logic [T_W-1:0]             t_rnd;
    logic [FRAC_W-1:0]          frac_c;
    logic signed [IP_W-1:0]     ip_rnd;
    logic signed [IP_W-1:0]     ip_sh;
    logic signed [IP_W-1:0]     ip_sum;
    logic signed [SAMPLE_W-1:0] ip_sat;
    logic                       out_free;

    // item decode
    assign smp_wr     = i_cmd.accept && (i_in_data.op == OP_SAMPLE);
    assign cidx_ext   = 9'(i_in_data.coef_index);
    assign coef_wr    = i_cmd.accept && (i_in_data.op == OP_COEF)
                        && (cidx_ext < 9'(NUM_TAPS));
    assign coef_waddr = cidx_ext[AW-1:0];
    assign rd_pos_dec = (r_rd_pos == '0) ? LAST_POS : r_rd_pos - 1'b1;
    assign wpos_inc   = (r_wpos == LAST_POS) ? '0 : r_wpos + 1'b1;

    // delay line memory
    always_ff @(posedge i_clk) begin
        if (smp_wr) begin
            r_dly_mem[r_wpos] <= i_in_data.sample_in;
        end
        if (i_cmd.mac_issue) begin
            r_dq <= r_dly_mem[r_rd_pos];
            r_dv <= r_dly_vld[r_rd_pos];
        end
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (coef_wr) begin
            r_coef_mem[coef_waddr] <= i_in_data.coef_value;
        end
        if (i_cmd.mac_issue) begin
            r_cq <= r_coef_mem[r_cnt];
            r_cv <= r_coef_vld[r_cnt];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_vld  <= '0;
            r_coef_vld <= '0;
        end else begin
            if (smp_wr) begin
                r_dly_vld[r_wpos] <= 1'b1;
            end
            if (coef_wr) begin
                r_coef_vld[coef_waddr] <= 1'b1;
            end
        end
    end

    assign dq_eff = r_dv ? r_dq : '0;
    assign cq_eff = r_cv ? r_cq : '0;

    // fir round half up and saturate
    assign acc_rnd = r_acc + ACC_W'(RND_HALF);
    assign acc_sh  = acc_rnd >>> Q_SH;
    always_comb begin
        if (acc_sh > ACC_HI) begin
            fir_sat = SAMPLE_W'(SMP_MAX);
        end else if (acc_sh < ACC_LO) begin
            fir_sat = SAMPLE_W'(SMP_MIN);
        end else begin
            fir_sat = acc_sh[SAMPLE_W-1:0];
        end
    end

    // phase step, clamped to four
    assign step_eff = (r_step > STEP_MAX) ? STEP_MAX : r_step;
    assign ph_m1    = PH_M1_W'(r_phase - PH_ONE);

    // fraction: one minus rounded (phase - 1) * inverse, floored at zero
    assign t_raw  = r_prod[PROD_W-1:PROD_SH];
    assign t_inc  = {1'b0, t_raw} + (T_W + 1)'(1);
    assign t_rnd  = t_inc[T_W:1];
    assign frac_c = (t_rnd >= T_W'(FRAC_ONE)) ? '0 : FRAC_W'(T_W'(FRAC_ONE) - t_rnd);

    // interpolated value, round half up and saturate
    assign ip_rnd = r_iprod + IP_W'(RND_HALF);
    assign ip_sh  = ip_rnd >>> Q_SH;
    assign ip_sum = IP_W'(r_prev) + ip_sh;
    always_comb begin
        if (ip_sum > IP_HI) begin
            ip_sat = SAMPLE_W'(SMP_MAX);
        end else if (ip_sum < IP_LO) begin
            ip_sat = SAMPLE_W'(SMP_MIN);
        end else begin
            ip_sat = ip_sum[SAMPLE_W-1:0];
        end
    end

    assign out_free = !r_out_vld || !i_out_stall;

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos    <= '0;
            r_rd_pos  <= '0;
            r_cnt     <= '0;
            r_q_vld   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_phase   <= '0;
            r_prev    <= '0;
            r_step    <= STEP_RST;
            r_inv     <= INV_RST;
            r_out_vld <= 1'b0;
        end else begin
            r_q_vld <= i_cmd.mac_issue;
            r_p_vld <= r_q_vld;
            if (smp_wr) begin
                r_rd_pos <= r_wpos;
                r_cnt    <= '0;
                r_wpos   <= wpos_inc;
            end else if (i_cmd.mac_issue) begin
                r_rd_pos <= rd_pos_dec;
                r_cnt    <= r_cnt + 1'b1;
            end
            if (i_cmd.fir_done) begin
                r_phase <= r_phase + step_eff;
            end else if (i_cmd.res_load) begin
                r_phase <= r_phase - PH_ONE;
            end
            if (i_cmd.item_done) begin
                r_prev <= r_cur;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STEP: r_step <= i_cfg_data;
                    CFG_INV:  r_inv  <= i_cfg_data;
                    default:  r_step <= r_step;
                endcase
            end
            if (i_cmd.res_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        if (r_q_vld) begin
            r_mprod <= dq_eff * cq_eff;
        end
        if (smp_wr) begin
            r_acc      <= '0;
            r_last_blk <= i_in_data.last_in_block;
        end else if (r_p_vld) begin
            r_acc <= r_acc + ACC_W'(r_mprod);
        end
        if (i_cmd.fir_done) begin
            r_cur <= fir_sat;
        end
        if (i_cmd.prod_load) begin
            r_prod <= ph_m1 * r_inv;
        end
        if (i_cmd.frac_load) begin
            r_frac <= frac_c;
            r_diff <= DIFF_W'(r_cur) - DIFF_W'(r_prev);
        end
        if (i_cmd.imul_load) begin
            r_iprod <= $signed({1'b0, r_frac}) * r_diff;
        end
        if (i_cmd.res_load) begin
            r_out.out_sample  <= ip_sat;
            r_out.last_of_run <= (r_phase < PH_TWO);
            r_out.block_end   <= (r_phase < PH_TWO) && r_last_blk;
        end
    end

    // status to the controller
    always_comb begin
        o_sts              = '0;
        o_sts.in_is_sample = (i_in_data.op == OP_SAMPLE);
        o_sts.mac_last     = (r_cnt == LAST_POS);
        o_sts.pipe_empty   = !r_q_vld && !r_p_vld;
        o_sts.phase_ge_one = (r_phase >= PH_ONE);
        o_sts.out_free     = out_free;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // every item leaves the phase below one
    a_phase_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> (r_phase < PH_ONE))
        else $error("item accepted with phase not below one");

    // a result is only formed when the phase allows it
    a_res_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (r_phase >= PH_ONE))
        else $error("result formed with phase below one");

    // a result never overwrites one still waiting
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (!r_out_vld || !i_out_stall))
        else $error("output register overwritten while stalled");

endmodule
